// ----- hw/rtl/blm_pkg.sv -----
// shared types and constants for the battery level monitor
`default_nettype none

package blm_pkg;

    localparam int ADC_W      = 12;
    localparam int MV_W       = 13;
    localparam int SUM_W      = 16;
    localparam int PCT_W      = 8;
    localparam int STORED_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int SAMPLES_DEFAULT = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_USB_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTORED      = 2'd1;

    localparam logic [MV_W-1:0]  USB_THRESHOLD_RESET = 13'd4300;
    localparam logic [PCT_W-1:0] RESTORED_RESET      = 8'hFF;

    // curve breakpoints
    localparam logic [MV_W-1:0] CURVE_FULL_MV = 13'd4200;
    localparam logic [MV_W-1:0] CURVE_HIGH_MV = 13'd3900;
    localparam logic [MV_W-1:0] CURVE_MID_MV  = 13'd3600;
    localparam logic [MV_W-1:0] CURVE_LOW_MV  = 13'd3300;

    localparam logic [STORED_W-1:0] PCT_FULL     = 7'd100;
    localparam logic [STORED_W-1:0] PCT_HIGH_BASE = 7'd50;
    localparam logic [STORED_W-1:0] PCT_MID_BASE  = 7'd10;
    localparam logic [STORED_W-1:0] PCT_EMPTY     = 7'd0;

    // reciprocal multipliers for the segment slopes
    localparam int SLOPE_W     = 12;
    localparam int DIFF_W      = 9;
    localparam int HIGH_SHIFT  = 12;
    localparam int MID_SHIFT   = 14;
    localparam int LOW_SHIFT   = 14;
    localparam logic [SLOPE_W-1:0] HIGH_MUL = SLOPE_W'((2**HIGH_SHIFT + 5) / 6);
    localparam logic [SLOPE_W-1:0] MID_MUL  = SLOPE_W'(2 * ((2**MID_SHIFT + 14) / 15));
    localparam logic [SLOPE_W-1:0] LOW_MUL  = SLOPE_W'((2**LOW_SHIFT + 29) / 30);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             pin;
    } blm_group_t;

endpackage

`default_nettype wire

// ----- hw/rtl/blm_front.sv -----
// front end: sample accumulation and group completion
`default_nettype none

module blm_front #(
    parameter int SAMPLES = 4
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [blm_pkg::ADC_W-1:0] adc_millivolts,
    input  wire logic                     charge_pin_low,
    input  wire logic                     fifo_full,
    output logic                          grp_push,
    output blm_pkg::blm_group_t           grp_data
);
    import blm_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MV_W-1:0]  mv2;
    logic [SUM_W-1:0] sum_full;
    logic             accept;
    logic             last;

    assign in_stall = fifo_full;
    assign accept   = in_valid && !fifo_full;
    assign mv2      = {adc_millivolts, 1'b0};
    assign sum_full = sum_reg + SUM_W'(mv2);
    assign last     = (cnt_reg == LAST_CNT);

    assign grp_push = accept && last;
    assign grp_data = {sum_full, charge_pin_low};

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (last)
            begin
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = sum_full;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/blm_fifo.sv -----
// two-entry queue of completed sample groups
`default_nettype none

module blm_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire blm_pkg::blm_group_t push_data,
    input  wire logic                pop,
    output blm_pkg::blm_group_t      pop_data,
    output logic                     full,
    output logic                     empty
);
    import blm_pkg::*;

    blm_group_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/blm_back.sv -----
// back end: averaging, usb detect, debounce and percent curve
`default_nettype none

module blm_back #(
    parameter int SAMPLES = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       grp_valid,
    input  wire blm_pkg::blm_group_t        grp_data,
    output logic                            grp_pop,
    input  wire logic [blm_pkg::MV_W-1:0]   usb_threshold,
    input  wire logic [blm_pkg::PCT_W-1:0]  restored_percent,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [blm_pkg::MV_W-1:0]        average_millivolts,
    output logic                            usb_present,
    output logic                            charging,
    output logic signed [blm_pkg::PCT_W-1:0] battery_percent
);
    import blm_pkg::*;

    // floor(sum / SAMPLES) as sum * ceil(2^19 / SAMPLES) >> 19, exact for 16-bit sums
    localparam int RECIP_SHIFT = SUM_W + 3;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2**RECIP_SHIFT + SAMPLES - 1) / SAMPLES);
    localparam int SPROD_W     = DIFF_W + SLOPE_W;

    localparam logic [2:0] SEG_EMPTY = 3'd0;
    localparam logic [2:0] SEG_LOW   = 3'd1;
    localparam logic [2:0] SEG_MID   = 3'd2;
    localparam logic [2:0] SEG_HIGH  = 3'd3;
    localparam logic [2:0] SEG_FULL  = 3'd4;

    // stage a: average
    logic              a_valid_reg;
    logic [MV_W-1:0]   a_avg_reg;
    logic              a_pin_reg;
    logic [PROD_W-1:0] div_prod;

    // stage b: segment and slope product
    logic               b_valid_reg;
    logic [MV_W-1:0]    b_avg_reg;
    logic               b_usb_reg;
    logic               b_pin_reg;
    logic [2:0]         b_seg_reg;
    logic [SPROD_W-1:0] b_prod_reg;
    logic [2:0]         seg;
    logic [MV_W-1:0]    base_mv;
    logic [SLOPE_W-1:0] slope;
    logic [MV_W-1:0]    diff_full;

    // output and debounce state
    logic                out_valid_reg;
    logic [MV_W-1:0]     avg_out_reg;
    logic                usb_out_reg;
    logic                chg_out_reg;
    logic [PCT_W-1:0]    pct_out_reg;
    logic [1:0]          obc_reg, obc_next;
    logic [STORED_W-1:0] stored_reg, stored_next;
    logic                known_reg, known_next;
    logic [STORED_W-1:0] curve;
    logic [PCT_W-1:0]    pct_next;

    logic out_ready;
    logic b_ready;
    logic a_ready;
    logic out_load;

    assign out_ready = !out_valid_reg || !out_stall;
    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign grp_pop   = grp_valid && a_ready;
    assign out_load  = b_valid_reg && out_ready;

    assign div_prod = PROD_W'(grp_data.sum) * PROD_W'(RECIP);

    always_comb
    begin
        if (a_avg_reg >= CURVE_FULL_MV)
        begin
            seg     = SEG_FULL;
            base_mv = CURVE_FULL_MV;
            slope   = '0;
        end
        else if (a_avg_reg >= CURVE_HIGH_MV)
        begin
            seg     = SEG_HIGH;
            base_mv = CURVE_HIGH_MV;
            slope   = HIGH_MUL;
        end
        else if (a_avg_reg >= CURVE_MID_MV)
        begin
            seg     = SEG_MID;
            base_mv = CURVE_MID_MV;
            slope   = MID_MUL;
        end
        else if (a_avg_reg >= CURVE_LOW_MV)
        begin
            seg     = SEG_LOW;
            base_mv = CURVE_LOW_MV;
            slope   = LOW_MUL;
        end
        else
        begin
            seg     = SEG_EMPTY;
            base_mv = '0;
            slope   = '0;
        end
    end

    assign diff_full = a_avg_reg - base_mv;

    always_comb
    begin
        case (b_seg_reg)
            SEG_FULL:  curve = PCT_FULL;
            SEG_HIGH:  curve = PCT_HIGH_BASE + b_prod_reg[HIGH_SHIFT +: STORED_W];
            SEG_MID:   curve = PCT_MID_BASE + b_prod_reg[MID_SHIFT +: STORED_W];
            SEG_LOW:   curve = b_prod_reg[LOW_SHIFT +: STORED_W];
            default:   curve = PCT_EMPTY;
        endcase
    end

    always_comb
    begin
        obc_next    = obc_reg;
        stored_next = stored_reg;
        known_next  = known_reg;
        if (b_usb_reg)
        begin
            obc_next = 2'd0;
        end
        else
        begin
            if (obc_reg < 2'd2)
            begin
                obc_next = obc_reg + 2'd1;
            end
            if (obc_next >= 2'd2)
            begin
                stored_next = curve;
                known_next  = 1'b1;
            end
        end
        pct_next = known_next ? {1'b0, stored_next} : restored_percent;
    end

    always_ff @(posedge clk)
    begin
        if (grp_pop)
        begin
            a_avg_reg <= div_prod[RECIP_SHIFT +: MV_W];
            a_pin_reg <= grp_data.pin;
        end
        if (a_valid_reg && b_ready)
        begin
            b_avg_reg  <= a_avg_reg;
            b_usb_reg  <= (a_avg_reg > usb_threshold);
            b_pin_reg  <= a_pin_reg;
            b_seg_reg  <= seg;
            b_prod_reg <= SPROD_W'(diff_full[DIFF_W-1:0]) * SPROD_W'(slope);
        end
        if (out_load)
        begin
            avg_out_reg <= b_avg_reg;
            usb_out_reg <= b_usb_reg;
            chg_out_reg <= b_usb_reg | b_pin_reg;
            pct_out_reg <= pct_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            obc_reg       <= 2'd0;
            stored_reg    <= '0;
            known_reg     <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= grp_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= b_valid_reg;
            end
            if (out_load)
            begin
                obc_reg    <= obc_next;
                stored_reg <= stored_next;
                known_reg  <= known_next;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign average_millivolts = avg_out_reg;
    assign usb_present        = usb_out_reg;
    assign charging           = chg_out_reg;
    assign battery_percent    = pct_out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/battery_level_monitor.sv -----
// top level of the battery level monitor
`default_nettype none

// Takes one converter reading per cycle (in_valid high, in_stall low) and
// emits one word per group of SAMPLES_PER_AVERAGE readings: the doubled
// average in millivolts, usb present, charging and the charge percentage.
// A sample is accepted every cycle unless the two-entry group queue is full;
// a group's word is written to the queue at the edge that accepts its last
// sample, then passes through the average multiply, the curve slope multiply
// and the output register in turn. The percentage follows
// a piecewise-linear LiPo curve once two consecutive on-battery averages
// have been seen; before that the restored_percent register is reported.
// Configuration writes are taken at any time and should be issued only
// while no group is in flight.

module battery_level_monitor #(
    parameter int SAMPLES_PER_AVERAGE = blm_pkg::SAMPLES_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [blm_pkg::ADC_W-1:0]      adc_millivolts,
    input  wire logic                           charge_pin_low,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [blm_pkg::MV_W-1:0]            average_millivolts,
    output logic                                usb_present,
    output logic                                charging,
    output logic signed [blm_pkg::PCT_W-1:0]    battery_percent,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [blm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [blm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import blm_pkg::*;

    logic [MV_W-1:0]  usb_threshold_reg, usb_threshold_next;
    logic [PCT_W-1:0] restored_reg, restored_next;

    logic       grp_push;
    logic       grp_pop;
    logic       fifo_full;
    logic       fifo_empty;
    blm_group_t grp_in;
    blm_group_t grp_out;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        usb_threshold_next = usb_threshold_reg;
        restored_next      = restored_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_USB_THRESHOLD: usb_threshold_next = cfg_data[MV_W-1:0];
                CFG_RESTORED:      restored_next      = cfg_data[PCT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usb_threshold_reg <= USB_THRESHOLD_RESET;
            restored_reg      <= RESTORED_RESET;
        end
        else
        begin
            usb_threshold_reg <= usb_threshold_next;
            restored_reg      <= restored_next;
        end
    end

    blm_front #(
        .SAMPLES (SAMPLES_PER_AVERAGE)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .adc_millivolts (adc_millivolts),
        .charge_pin_low (charge_pin_low),
        .fifo_full      (fifo_full),
        .grp_push       (grp_push),
        .grp_data       (grp_in)
    );

    blm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (grp_push),
        .push_data (grp_in),
        .pop       (grp_pop),
        .pop_data  (grp_out),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    blm_back #(
        .SAMPLES (SAMPLES_PER_AVERAGE)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .grp_valid          (!fifo_empty),
        .grp_data           (grp_out),
        .grp_pop            (grp_pop),
        .usb_threshold      (usb_threshold_reg),
        .restored_percent   (restored_reg),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .average_millivolts (average_millivolts),
        .usb_present        (usb_present),
        .charging           (charging),
        .battery_percent    (battery_percent)
    );

`ifndef SYNTHESIS
    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(grp_push && fifo_full))
        else $error("group pushed into a full queue");

    a_no_queue_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        grp_pop |-> !fifo_empty)
        else $error("group popped from an empty queue");

    a_usb_implies_charging: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && usb_present) |-> charging)
        else $error("usb present without charging flag");

    a_usb_matches_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && $rose(out_valid) && !$past(cfg_valid))
            |-> (usb_present == (average_millivolts > usb_threshold_reg)))
        else $error("usb flag disagrees with threshold");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_battery_level_monitor.sv -----
// self-checking testbench for the battery level monitor
`default_nettype none

module tb_battery_level_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    import blm_pkg::*;

    localparam int SAMPLES        = SAMPLES_DEFAULT;
    localparam int PIPE_SLACK     = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct {
        logic [ADC_W-1:0] mv;
        logic             pin;
    } adc_reading_t;

    typedef struct {
        logic [MV_W-1:0]         average_mv;
        logic                    usb;
        logic                    charging;
        logic signed [PCT_W-1:0] percent;
    } battery_word_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [ADC_W-1:0]        adc_millivolts = '0;
    logic                    charge_pin_low = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [MV_W-1:0]         average_millivolts;
    logic                    usb_present;
    logic                    charging;
    logic signed [PCT_W-1:0] battery_percent;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    adc_reading_t  pending_readings[$];
    battery_word_t expected_words[$];

    // predictor state
    logic [MV_W-1:0]     usb_threshold = USB_THRESHOLD_RESET;
    logic [PCT_W-1:0]    restored_pct  = RESTORED_RESET;
    logic [SUM_W-1:0]    group_sum     = '0;
    logic [3:0]          group_count   = '0;
    logic [1:0]          on_battery_run = '0;
    logic [STORED_W-1:0] stored_pct    = '0;
    logic                pct_known     = 1'b0;

    int           mismatch_count = 0;
    int           quiet_cycles = 0;
    int           queued_total = 0;
    int           send_idle_left = 0;
    int           stall_left = 0;
    bit           sender_idles = 1'b0;
    bit           receiver_stalls = 1'b0;
    adc_reading_t next_reading;
    battery_word_t got_word;
    battery_word_t want_word;

    battery_level_monitor #(
        .SAMPLES_PER_AVERAGE(SAMPLES)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .adc_millivolts    (adc_millivolts),
        .charge_pin_low    (charge_pin_low),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .average_millivolts(average_millivolts),
        .usb_present       (usb_present),
        .charging          (charging),
        .battery_percent   (battery_percent),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [STORED_W-1:0] lipo_curve_percent(input logic [MV_W-1:0] mv);
        int v;
        v = int'(mv);
        if (mv >= CURVE_FULL_MV)
            return STORED_W'(100);
        if (mv >= CURVE_HIGH_MV)
            return STORED_W'(50 + (v - 3900) * 50 / 300);
        if (mv >= CURVE_MID_MV)
            return STORED_W'(10 + (v - 3600) * 40 / 300);
        if (mv >= CURVE_LOW_MV)
            return STORED_W'((v - 3300) * 10 / 300);
        return STORED_W'(0);
    endfunction

    task automatic predict_reading(input logic [ADC_W-1:0] mv, input logic pin);
        battery_word_t w;
        logic [MV_W-1:0] avg;
        logic usb;
        group_sum = group_sum + SUM_W'({mv, 1'b0});
        group_count = group_count + 4'd1;
        if (int'(group_count) < SAMPLES)
            return;
        avg = MV_W'(int'(group_sum) / int'(group_count));
        group_sum = '0;
        group_count = '0;
        usb = (avg > usb_threshold);
        if (usb)
            on_battery_run = 2'd0;
        else
        begin
            if (on_battery_run < 2'd2)
                on_battery_run = on_battery_run + 2'd1;
            if (on_battery_run >= 2'd2)
            begin
                stored_pct = lipo_curve_percent(avg);
                pct_known = 1'b1;
            end
        end
        w.average_mv = avg;
        w.usb = usb;
        w.charging = usb | pin;
        w.percent = pct_known ? {1'b0, stored_pct} : restored_pct;
        expected_words.push_back(w);
    endtask

    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            adc_millivolts <= '0;
            charge_pin_low <= 1'b0;
            send_idle_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_reading(adc_millivolts, charge_pin_low);
            if (!in_valid || !in_stall)
            begin
                if (send_idle_left > 0)
                begin
                    in_valid <= 1'b0;
                    send_idle_left = send_idle_left - 1;
                end
                else if (pending_readings.size() > 0)
                begin
                    next_reading = pending_readings.pop_front();
                    in_valid <= 1'b1;
                    adc_millivolts <= next_reading.mv;
                    charge_pin_low <= next_reading.pin;
                    send_idle_left = pick_gap(sender_idles);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_word.average_mv = average_millivolts;
                got_word.usb = usb_present;
                got_word.charging = charging;
                got_word.percent = battery_percent;
                if (expected_words.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected word avg=%0d usb=%0b chg=%0b pct=%0d",
                                 $time, got_word.average_mv, got_word.usb,
                                 got_word.charging, got_word.percent);
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    if (got_word.average_mv !== want_word.average_mv ||
                        got_word.usb !== want_word.usb ||
                        got_word.charging !== want_word.charging ||
                        got_word.percent !== want_word.percent)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $write("%0t: word mismatch, expected avg=%0d usb=%0b chg=%0b",
                                   $time, want_word.average_mv, want_word.usb,
                                   want_word.charging);
                            $display(" pct=%0d, got avg=%0d usb=%0b chg=%0b pct=%0d",
                                     want_word.percent, got_word.average_mv,
                                     got_word.usb, got_word.charging, got_word.percent);
                        end
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                stall_left = pick_gap(receiver_stalls);
                if (stall_left > 0)
                begin
                    out_stall <= 1'b1;
                    stall_left = stall_left - 1;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_USB_THRESHOLD: usb_threshold = data;
            CFG_RESTORED:      restored_pct = data[PCT_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_readings.size() != 0 || in_valid || expected_words.size() != 0);
        repeat (PIPE_SLACK) @(negedge clk);
    endtask

    task automatic queue_reading(input logic [ADC_W-1:0] mv, input logic pin);
        adc_reading_t r;
        r.mv = mv;
        r.pin = pin;
        pending_readings.push_back(r);
        queued_total++;
    endtask

    task automatic queue_flat_group(input logic [ADC_W-1:0] mv, input logic [3:0] pins);
        for (int k = 0; k < SAMPLES; k++)
            queue_reading(mv, pins[k]);
    endtask

    task automatic queue_random_readings(input int count);
        int r;
        int base;
        int v;
        base = 0;
        for (int k = 0; k < count; k++)
        begin
            if (queued_total % SAMPLES == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    base = $urandom_range(1550, 2200);
                else if (r < 80)
                    base = $urandom_range(2100, 2600);
                else
                    base = $urandom_range(0, 4095);
            end
            if ($urandom_range(0, 9) == 0)
                v = $urandom_range(0, 4095);
            else
                v = base + int'($urandom_range(0, 24)) - 12;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            queue_reading(ADC_W'(v), 1'($urandom_range(0, 1)));
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return 13'd8191;
            2:       return 13'd8190;
            3, 4:    return USB_THRESHOLD_RESET;
            5:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(3000, 4600));
        endcase
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // usb rail present, restored value reported
        queue_flat_group(12'd2200, 4'b0000);
        wait_for_drain();
        write_reg(CFG_RESTORED, 13'h1F7F);
        write_reg(CFG_SPARE_2, 13'h1FFF);
        write_reg(CFG_SPARE_3, 13'h0000);
        @(negedge clk);
        // pin counts only on the closing sample
        queue_flat_group(12'd0, 4'b0111);
        wait_for_drain();
        write_reg(CFG_RESTORED, 13'h0080);
        @(negedge clk);
        // usb clears the on-battery run
        queue_flat_group(12'd4095, 4'b1000);
        queue_flat_group(12'd1900, 4'b0000);
        wait_for_drain();
        write_reg(CFG_RESTORED, 13'h0064);
        write_reg(CFG_USB_THRESHOLD, 13'd0);
        @(negedge clk);
        queue_flat_group(12'd0, 4'b1111);
        wait_for_drain();
        // restored value no longer matters once a percentage is known
        write_reg(CFG_RESTORED, 13'h0032);
        write_reg(CFG_USB_THRESHOLD, 13'd8191);
        @(negedge clk);
        queue_flat_group(12'd4095, 4'b0000);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_for_drain();
            write_reg(CFG_USB_THRESHOLD, pick_threshold());
            write_reg(CFG_RESTORED, CFG_DATA_W'($urandom));
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                          CFG_DATA_W'($urandom));
            @(negedge clk);
            sender_idles = (ph % 3 != 0);
            receiver_stalls = (ph % 3 != 1);
            queue_random_readings($urandom_range(170, 180));
        end

        wait_for_drain();
        mismatch_count += expected_words.size();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
